// ===== hw/rtl/pee_pkg.sv =====
package pee_pkg;

  // Stack geometry and word widths.
  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OPND_W      = 31;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned DIV_CNT_W   = $clog2(DATA_W + 1);

  // Request kinds.
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_OPER = 1'b1;

  // Operator codes.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_DIV = 2'd2;
  localparam logic [1:0] OP_MUL = 2'd3;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_COUNT     = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    push;
    logic    raise;
    status_e raise_code;
    logic    rd;
    logic    alu_wb;
    logic    div_start;
    logic    div_wb;
    logic    finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic err_set;
    logic is_oper;
    logic is_div;
    logic is_last;
    logic lt2;
    logic full;
    logic div_zero;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hw/rtl/pee_tok_if.sv =====
interface pee_tok_if
  import pee_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [OPND_W-1:0] operand_value;
  logic [1:0]        operator_code;
  logic              end_of_expression;

  modport source (
    output valid, req_type, operand_value, operator_code, end_of_expression,
    input  ready
  );
  modport sink (
    input  valid, req_type, operand_value, operator_code, end_of_expression,
    output ready
  );
endinterface

// ===== hw/rtl/pee_res_if.sv =====
interface pee_res_if
  import pee_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic [2:0]               status;

  modport source (
    output valid, result_value, status,
    input  ready
  );
  modport sink (
    input  valid, result_value, status,
    output ready
  );
endinterface

// ===== hw/rtl/pee_ram.sv =====
module pee_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 32,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port, single registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/pee_div.sv =====
module pee_div
  import pee_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quotient_o
);

  logic [DATA_W-1:0]    quo_q;
  logic [DATA_W-1:0]    dsr_q;
  logic [DATA_W-1:0]    rem_q;
  logic                 neg_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [DATA_W:0]      shifted;
  logic [DATA_W:0]      trial;
  logic                 fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign trial   = shifted - {1'b0, dsr_q};
  assign fits    = ~trial[DATA_W];

  // Magnitudes are divided; the sign is applied to the quotient at the end.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i[DATA_W-1] ? (~dividend_i + DATA_W'(1)) : dividend_i;
      dsr_q <= divisor_i[DATA_W-1] ? (~divisor_i + DATA_W'(1)) : divisor_i;
      rem_q <= '0;
      neg_q <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
    end else if (busy_q) begin
      rem_q <= fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_q <= {quo_q[DATA_W-2:0], fits};
    end
  end

  // Iteration counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= DIV_CNT_W'(DATA_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + DATA_W'(1)) : quo_q;

endmodule

// ===== hw/rtl/pee_dp.sv =====
module pee_dp
  import pee_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_stat_t                 stat_o,
  input  logic                     req_type_i,
  input  logic [OPND_W-1:0]        operand_value_i,
  input  logic [1:0]               operator_code_i,
  input  logic                     end_of_expression_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output logic signed [DATA_W-1:0] result_value_o,
  output logic [2:0]               status_o
);

  logic              tok_type_q;
  logic [OPND_W-1:0] tok_value_q;
  logic [1:0]        tok_code_q;
  logic              tok_last_q;
  logic [CNT_W-1:0]  count_q, count_d;
  status_e           err_q, err_d;
  logic [DATA_W-1:0] tos_q, tos_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q;
  status_e           out_status_q;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  logic [DATA_W-1:0] ram_rdata;
  logic [DATA_W-1:0] mul_res;
  logic [DATA_W-1:0] alu_res;
  logic [DATA_W-1:0] div_quo;
  logic              div_done;
  logic              ram_we;

  // Token capture on acceptance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tok_type_q  <= req_type_i;
      tok_value_q <= operand_value_i;
      tok_code_q  <= operator_code_i;
      tok_last_q  <= end_of_expression_i;
    end
  end

  // Top of stack lives in tos_q; the entries beneath it live in the RAM.
  assign cnt_m1 = count_q - CNT_W'(1);
  assign cnt_m2 = count_q - CNT_W'(2);
  assign ram_we = cmd_i.push && (count_q != '0);

  pee_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_m1[ADDR_W-1:0]),
    .wdata_i (tos_q),
    .re_i    (cmd_i.rd),
    .raddr_i (cnt_m2[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Iterative divider for the divide operator.
  pee_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (ram_rdata),
    .divisor_i  (tos_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Add, subtract and multiply; the first operand comes from the RAM.
  assign mul_res = ram_rdata * tos_q;

  always_comb begin
    case (tok_code_q)
      OP_ADD:  alu_res = ram_rdata + tos_q;
      OP_SUB:  alu_res = ram_rdata - tos_q;
      default: alu_res = mul_res;
    endcase
  end

  // Next values of the stack, the error latch and the output slot.
  always_comb begin
    count_d     = count_q;
    err_d       = err_q;
    tos_d       = tos_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && res_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.push) begin
      tos_d   = {1'b0, tok_value_q};
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.raise) begin
      if (err_q == ST_OK) begin
        err_d = cmd_i.raise_code;
      end
      count_d = '0;
    end
    if (cmd_i.alu_wb) begin
      tos_d   = alu_res;
      count_d = cnt_m1;
    end
    if (cmd_i.div_wb) begin
      tos_d   = div_quo;
      count_d = cnt_m1;
    end
    if (cmd_i.finish) begin
      count_d     = '0;
      err_d       = ST_OK;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
  end

  // End-of-expression report.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (err_q != ST_OK) begin
        out_value_q  <= '0;
        out_status_q <= err_q;
      end else if (count_q == CNT_W'(1)) begin
        out_value_q  <= tos_q;
        out_status_q <= ST_OK;
      end else begin
        out_value_q  <= '0;
        out_status_q <= ST_COUNT;
      end
    end
  end

  assign res_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign status_o       = out_status_q;

  // Status towards the controller.
  assign stat_o.err_set  = (err_q != ST_OK);
  assign stat_o.is_oper  = (tok_type_q == REQ_OPER);
  assign stat_o.is_div   = (tok_code_q == OP_DIV);
  assign stat_o.is_last  = tok_last_q;
  assign stat_o.lt2      = (count_q < CNT_W'(2));
  assign stat_o.full     = (count_q >= CNT_W'(STACK_DEPTH));
  assign stat_o.div_zero = (tos_q == '0);
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = ~out_valid_q | res_ready_i;

endmodule

// ===== hw/rtl/pee_ctrl.sv =====
module pee_ctrl
  import pee_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] after_tok;

  // A final token goes on to the report; any other returns to idle.
  assign after_tok  = stat_i.is_last ? S_FIN : S_IDLE;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.raise_code = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = after_tok;
        if (!stat_i.err_set) begin
          if (!stat_i.is_oper) begin
            if (stat_i.full) begin
              cmd_o.raise      = 1'b1;
              cmd_o.raise_code = ST_OVERFLOW;
            end else begin
              cmd_o.push = 1'b1;
            end
          end else if (stat_i.lt2) begin
            cmd_o.raise      = 1'b1;
            cmd_o.raise_code = ST_UNDERFLOW;
          end else begin
            cmd_o.rd = 1'b1;
            state_d  = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        // The first operand is now out of the RAM.
        state_d = after_tok;
        if (!stat_i.is_div) begin
          cmd_o.alu_wb = 1'b1;
        end else if (stat_i.div_zero) begin
          cmd_o.raise      = 1'b1;
          cmd_o.raise_code = ST_DIVZERO;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.div_wb = 1'b1;
          state_d      = after_tok;
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/postfix_expression_evaluator_top.sv =====
// Postfix expression evaluator.
// Tokens arrive on tok_i, a valid/ready channel: each request is either an
// operand push or an operator, and the last token of an expression carries
// end_of_expression. One result request per expression leaves on res_o with
// the final value and a status code; other tokens produce no result.
// A push returns to ready after the decode state; an add, subtract or multiply
// also passes an execute state, because the operand beneath the top of stack
// is read from the stack RAM, whose read port is registered. A divide then
// waits in a divide state on the iterative divider, which retires one quotient
// bit per cycle. A final token then writes the output register.
// The output register frees the token side from the receiver: a result waits
// there while the next tokens are accepted, and only a further final token
// stalls, until the waiting result has been taken.
// Reset empties the stack, clears the error latch and the output valid flag;
// the stack RAM itself needs no clearing since only written entries are read.
module postfix_expression_evaluator_top
  import pee_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  pee_tok_if.sink   tok_i,
  pee_res_if.source res_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencing of each token.
  pee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (tok_i.valid),
    .in_ready_o (tok_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Stack, arithmetic and result register.
  pee_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .req_type_i          (tok_i.req_type),
    .operand_value_i     (tok_i.operand_value),
    .operator_code_i     (tok_i.operator_code),
    .end_of_expression_i (tok_i.end_of_expression),
    .res_valid_o         (res_o.valid),
    .res_ready_i         (res_o.ready),
    .result_value_o      (res_o.result_value),
    .status_o            (res_o.status)
  );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import pee_pkg::*;

  localparam int unsigned HALF_PERIOD  = 10;
  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 64;

  // One token request as offered on the input channel.
  typedef struct packed {
    logic              kind;
    logic [OPND_W-1:0] value;
    logic [1:0]        code;
    logic              last;
  } token_t;

  // One result request as it should leave the block.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    status_e           status;
  } result_t;

  // Directed row: a token, and for the obvious cases the result typed in.
  typedef struct packed {
    logic              kind;
    logic [OPND_W-1:0] value;
    logic [1:0]        code;
    logic              last;
    logic              known;
    logic [DATA_W-1:0] want_value;
    status_e           want_status;
  } dir_row_t;

  // Operand and operator fields that a token does not use carry junk on purpose.
  localparam dir_row_t DIRECTED [25] = '{
    // Largest operand alone, then zero alone.
    '{REQ_PUSH, 31'h7FFFFFFF, OP_MUL, 1'b1, 1'b1, 32'h7FFFFFFF, ST_OK},
    '{REQ_PUSH, 31'h00000000, OP_DIV, 1'b1, 1'b1, 32'h00000000, ST_OK},
    // Plain subtraction.
    '{REQ_PUSH, 31'd5,        OP_ADD, 1'b0, 1'b0, 32'h0, ST_OK},
    '{REQ_PUSH, 31'd3,        OP_SUB, 1'b0, 1'b0, 32'h0, ST_OK},
    '{REQ_OPER, 31'h7FFFFFFF, OP_SUB, 1'b1, 1'b0, 32'h0, ST_OK},
    // Operator on an empty stack.
    '{REQ_OPER, 31'h2AAAAAAA, OP_ADD, 1'b1, 1'b1, 32'h0, ST_UNDERFLOW},
    // Division by zero.
    '{REQ_PUSH, 31'd1,        OP_MUL, 1'b0, 1'b0, 32'h0, ST_OK},
    '{REQ_PUSH, 31'd0,        OP_SUB, 1'b0, 1'b0, 32'h0, ST_OK},
    '{REQ_OPER, 31'h55555555, OP_DIV, 1'b1, 1'b1, 32'h0, ST_DIVZERO},
    // Two values left at the end.
    '{REQ_PUSH, 31'd1,        OP_ADD, 1'b0, 1'b0, 32'h0, ST_OK},
    '{REQ_PUSH, 31'd2,        OP_ADD, 1'b1, 1'b1, 32'h0, ST_COUNT},
    // Build the most negative value and minus one, then divide: it wraps.
    '{REQ_PUSH, 31'd0,        OP_ADD, 1'b0, 1'b0, 32'h0, ST_OK},
    '{REQ_PUSH, 31'h7FFFFFFF, OP_ADD, 1'b0, 1'b0, 32'h0, ST_OK},
    '{REQ_OPER, 31'h0,        OP_SUB, 1'b0, 1'b0, 32'h0, ST_OK},
    '{REQ_PUSH, 31'd1,        OP_DIV, 1'b0, 1'b0, 32'h0, ST_OK},
    '{REQ_OPER, 31'h7FFFFFFF, OP_SUB, 1'b0, 1'b0, 32'h0, ST_OK},
    '{REQ_PUSH, 31'd0,        OP_MUL, 1'b0, 1'b0, 32'h0, ST_OK},
    '{REQ_PUSH, 31'd1,        OP_SUB, 1'b0, 1'b0, 32'h0, ST_OK},
    '{REQ_OPER, 31'h0,        OP_SUB, 1'b0, 1'b0, 32'h0, ST_OK},
    '{REQ_OPER, 31'h1,        OP_DIV, 1'b1, 1'b1, 32'h80000000, ST_OK},
    // Wrapping multiply followed by an add.
    '{REQ_PUSH, 31'h7FFFFFFF, OP_DIV, 1'b0, 1'b0, 32'h0, ST_OK},
    '{REQ_PUSH, 31'h7FFFFFFF, OP_SUB, 1'b0, 1'b0, 32'h0, ST_OK},
    '{REQ_OPER, 31'h0,        OP_MUL, 1'b0, 1'b0, 32'h0, ST_OK},
    '{REQ_PUSH, 31'd3,        OP_MUL, 1'b0, 1'b0, 32'h0, ST_OK},
    '{REQ_OPER, 31'h0,        OP_ADD, 1'b1, 1'b0, 32'h0, ST_OK}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  pee_tok_if tok ();
  pee_res_if res ();

  postfix_expression_evaluator_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tok_i  (tok),
    .res_o  (res)
  );

  // Evaluation state mirrored from the block, plus results still to arrive.
  logic [DATA_W-1:0] calc_stack [STACK_DEPTH];
  int unsigned       calc_depth = 0;
  status_e           calc_err   = ST_OK;
  result_t           pending_results [$];

  int unsigned tokens_sent      = 0;
  int unsigned expressions_sent = 0;
  int unsigned results_checked  = 0;
  int unsigned mismatches       = 0;
  int unsigned cycle_cnt        = 0;
  int unsigned status_hits [5]  = '{default: 0};

  bit          quiet        = 1'b0;
  bit          hold_request = 1'b0;
  bit          sender_calm  = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned stall_left   = 0;
  int unsigned calm_left    = 0;

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // An error keeps only the first code and empties the stack.
  function automatic void latch_error(input status_e code);
    if (calc_err == ST_OK) calc_err = code;
    calc_depth = 0;
  endfunction

  // Applies one token; returns 1 with the result when the token ends an expression.
  function automatic bit eval_token(input token_t t, output result_t r);
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
    logic [DATA_W-1:0] acc;
    longint            quo;
    bit                ok;
    r = '0;
    if (calc_err == ST_OK) begin
      if (t.kind == REQ_PUSH) begin
        if (calc_depth >= STACK_DEPTH) begin
          latch_error(ST_OVERFLOW);
        end else begin
          calc_stack[calc_depth] = {1'b0, t.value};
          calc_depth++;
        end
      end else if (calc_depth < 2) begin
        latch_error(ST_UNDERFLOW);
      end else begin
        rhs = calc_stack[calc_depth-1];
        lhs = calc_stack[calc_depth-2];
        ok  = 1'b1;
        acc = '0;
        case (t.code)
          OP_ADD: acc = lhs + rhs;
          OP_SUB: acc = lhs - rhs;
          OP_MUL: acc = lhs * rhs;
          default: begin
            if (rhs == '0) begin
              latch_error(ST_DIVZERO);
              ok = 1'b0;
            end else begin
              // Divide in 64 bits so that the one overflowing case wraps cleanly.
              quo = longint'($signed(lhs)) / longint'($signed(rhs));
              acc = quo[DATA_W-1:0];
            end
          end
        endcase
        if (ok) begin
          calc_depth--;
          calc_stack[calc_depth-1] = acc;
        end
      end
    end
    if (!t.last) return 1'b0;
    if (calc_err != ST_OK) r = '{value: '0, status: calc_err};
    else if (calc_depth == 1) r = '{value: calc_stack[0], status: ST_OK};
    else r = '{value: '0, status: ST_COUNT};
    calc_depth = 0;
    calc_err   = ST_OK;
    return 1'b1;
  endfunction

  function automatic logic [OPND_W-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return OPND_W'(1);
      2:       return '1;
      3:       return OPND_W'($urandom_range(0, 9));
      4, 5:    return OPND_W'($urandom_range(0, 1000));
      default: return OPND_W'($urandom());
    endcase
  endfunction

  function automatic token_t push_tok(input logic [OPND_W-1:0] v);
    return '{kind: REQ_PUSH, value: v, code: 2'($urandom_range(0, 3)), last: 1'b0};
  endfunction

  function automatic token_t oper_tok();
    return '{kind: REQ_OPER, value: OPND_W'($urandom()), code: 2'($urandom_range(0, 3)),
             last: 1'b0};
  endfunction

  // Offers one token, waits for it to be taken and records what it should yield.
  task automatic send_token(input token_t t, input bit known, input result_t want);
    result_t got;
    if (!quiet && !sender_calm && $urandom_range(0, 9) == 0) begin
      tok.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    tok.valid             = 1'b1;
    tok.req_type          = t.kind;
    tok.operand_value     = t.value;
    tok.operator_code     = t.code;
    tok.end_of_expression = t.last;
    do @(posedge clk_i); while (!tok.ready);
    if (eval_token(t, got)) pending_results.push_back(known ? want : got);
    tokens_sent++;
    if (t.last) expressions_sent++;
    @(negedge clk_i);
  endtask

  // Stops offering tokens until every outstanding result has been taken.
  task automatic wait_drained();
    tok.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Builds one expression: mostly well formed, some deep, some overflowing,
  // some broken at the end, and some plain noise.
  task automatic send_expr();
    token_t      seq [$];
    result_t     none;
    int unsigned shape;
    int unsigned left;
    int          depth;
    bit          deep;
    none        = '0;
    sender_calm = ($urandom_range(0, 3) == 0);
    shape       = $urandom_range(0, 19);
    deep        = (shape == 12 || shape == 13);
    if (shape <= 13 || shape >= 17) begin
      left  = deep ? $urandom_range(16, STACK_DEPTH) : $urandom_range(1, 6);
      depth = 0;
      while (left > 0 || depth > 1) begin
        if (left > 0 && (depth < 2 || deep || $urandom_range(0, 1) == 1)) begin
          seq.push_back(push_tok(pick_operand()));
          left--;
          depth++;
        end else begin
          seq.push_back(oper_tok());
          depth--;
        end
      end
      // Broken variants: drop the last operator or leave an extra operand.
      if (shape >= 17) begin
        if (seq.size() > 1 && $urandom_range(0, 1) == 1) void'(seq.pop_back());
        else seq.push_back(push_tok(pick_operand()));
      end
    end else if (shape == 14) begin
      repeat ($urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 3))
        seq.push_back(push_tok(pick_operand()));
      repeat ($urandom_range(0, 3))
        seq.push_back($urandom_range(0, 1) ? oper_tok() : push_tok(pick_operand()));
    end else begin
      repeat ($urandom_range(1, 10))
        seq.push_back($urandom_range(0, 1) ? oper_tok() : push_tok(pick_operand()));
    end
    seq[seq.size()-1].last = 1'b1;
    foreach (seq[i]) send_token(seq[i], 1'b0, none);
  endtask

  // Result side: random stalls, calm stretches and one long hold-off on request.
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready = 1'b0;
      end else if (quiet) begin
        res.ready = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res.ready = 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        res.ready = 1'b1;
      end else if ($urandom_range(0, 63) == 0) begin
        calm_left = $urandom_range(50, 200);
        res.ready = 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 13);
        res.ready  = 1'b0;
      end else begin
        res.ready = 1'b1;
      end
    end
  end

  // Each result taken is compared with the oldest outstanding one.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: result_value %0d, status %0d",
               res.result_value, res.status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        status_hits[want.status]++;
        if (res.result_value !== want.value) begin
          $error("result_value: expected %0d, got %0d", $signed(want.value),
                 res.result_value);
          mismatches++;
        end
        if (res.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res.status);
          mismatches++;
        end
      end
    end
  end

  // Cycle limit for a hung block.
  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding.", cycle_cnt,
             pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  // Main sequence: reset, directed rows, random phases, quiet finish.
  initial begin
    token_t  t;
    result_t w;
    tok.valid             = 1'b0;
    tok.req_type          = REQ_PUSH;
    tok.operand_value     = '0;
    tok.operator_code     = OP_ADD;
    tok.end_of_expression = 1'b0;
    rst_ni                = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED[i]) begin
      t = '{kind: DIRECTED[i].kind, value: DIRECTED[i].value, code: DIRECTED[i].code,
            last: DIRECTED[i].last};
      w = '{value: DIRECTED[i].want_value, status: DIRECTED[i].want_status};
      send_token(t, DIRECTED[i].known, w);
    end
    wait_drained();

    while (tokens_sent < 800) send_expr();

    // Hold the result side off while tokens keep coming, so the input stalls.
    hold_request = 1'b1;
    while (tokens_sent < 950) send_expr();
    wait_drained();

    while (tokens_sent < 1550) send_expr();

    // Last stretch runs flat out on both sides.
    quiet = 1'b1;
    while (tokens_sent < 1900) send_expr();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Checked %0d results from %0d tokens in %0d expressions, with one long stall.",
             results_checked, tokens_sent, expressions_sent);
    $display("Statuses: ok %0d, underflow %0d, bad count %0d, divide by zero %0d, overflow %0d.",
             status_hits[ST_OK], status_hits[ST_UNDERFLOW], status_hits[ST_COUNT],
             status_hits[ST_DIVZERO], status_hits[ST_OVERFLOW]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
